### design/tdp_pkg.sv
// Shared constants, types and state encoding for the trial division primality tester.
`timescale 1ns / 1ps

package tdp_pkg;

  localparam int DATA_W         = 32;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_W          = DATA_W / 2 + 1;
  localparam int SQ_W           = 2 * DIV_W;
  localparam int BITS_PER_CYCLE = 4;
  localparam int DIV_CYCLES     = DATA_W / BITS_PER_CYCLE;
  localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);

  // mod 3 folding: base-4 digit sum, then a second fold of that sum
  localparam int FOLD_W         = $clog2(3 * (DATA_W / 2) + 1);
  localparam int FOLD_PAIRS     = (FOLD_W + 1) / 2;
  localparam int FOLD_SUM_W     = 2 * FOLD_PAIRS;

  localparam logic [DIV_W-1:0] FIRST_DIV  = DIV_W'(5);
  localparam logic [DIV_W-1:0] PAIR_STEP  = DIV_W'(2);
  localparam logic [DIV_W-1:0] WHEEL_STEP = DIV_W'(6);
  localparam logic [DATA_W-1:0] SMALL_MAX = DATA_W'(3);

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              resolved;
    logic              flag;
  } tdp_entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_START,
    BK_DIVIDE,
    BK_SQUARE,
    BK_BOUND,
    BK_DONE
  } bk_state_e;

endpackage

### design/tdp_intf.sv
// Valid/ready channel interfaces for the input items and the result items.
`timescale 1ns / 1ps

interface tdp_in_if
  import tdp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface tdp_out_if;
  logic valid;
  logic ready;
  logic prime_flag;

  modport source (output valid, output prime_flag, input ready);
  modport sink   (input valid, input prime_flag, output ready);
endinterface

### design/tdp_front.sv
// Front end: takes input items and settles the trivial cases before queuing.
`timescale 1ns / 1ps

module tdp_front
  import tdp_pkg::*;
(
  tdp_in_if.sink     in_i,
  input  logic       full_i,
  output logic       push_o,
  output tdp_entry_t entry_o
);

  logic [DATA_W-1:0]     val;
  logic [FOLD_SUM_W-1:0] fold1;
  logic [3:0]            fold2;
  logic                  by3;

  assign val         = in_i.value;
  assign in_i.ready  = !full_i;
  assign push_o      = in_i.valid && !full_i;

  // 4 = 1 mod 3, so summing base-4 digits keeps the residue
  always_comb begin
    fold1 = '0;
    for (int i = 0; i < DATA_W / 2; i++) begin
      fold1 = fold1 + FOLD_SUM_W'(val[2*i +: 2]);
    end
    fold2 = '0;
    for (int j = 0; j < FOLD_PAIRS; j++) begin
      fold2 = fold2 + 4'(fold1[2*j +: 2]);
    end
    by3 = fold2 inside {4'd0, 4'd3, 4'd6, 4'd9, 4'd12};
  end

  always_comb begin
    entry_o.value    = val;
    entry_o.resolved = 1'b1;
    entry_o.flag     = 1'b0;
    if (val[DATA_W-1]) begin
      // negative: never prime
      entry_o.flag = 1'b0;
    end else if (val <= SMALL_MAX) begin
      entry_o.flag = (val > DATA_W'(1));
    end else if (!val[0] || by3) begin
      entry_o.flag = 1'b0;
    end else begin
      entry_o.resolved = 1'b0;
    end
  end

endmodule

### design/tdp_queue.sv
// Small FIFO between the front end and the trial division engine.
`timescale 1ns / 1ps

module tdp_queue
  import tdp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  tdp_entry_t entry_i,
  input  logic       pop_i,
  output tdp_entry_t head_o,
  output logic       full_o,
  output logic       empty_o
);

  tdp_entry_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

### design/tdp_divider.sv
// Restoring remainder unit, a few quotient bits per cycle.
`timescale 1ns / 1ps

module tdp_divider
  import tdp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [DIV_W-1:0]  rem_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DATA_W-1:0]    quo_q, quo_d;
  logic [DIV_W-1:0]     rem_q, rem_d, dvs_q;

  always_comb begin
    logic [DIV_W:0] trial;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int s = 0; s < BITS_PER_CYCLE; s++) begin
      trial = {rem_d, quo_d[DATA_W-1]};
      quo_d = {quo_d[DATA_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        trial = trial - {1'b0, dvs_q};
      end
      rem_d = trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### design/tdp_back.sv
// Back end: 6k +/- 1 trial division sequencer and result register.
`timescale 1ns / 1ps

module tdp_back
  import tdp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tdp_entry_t head_i,
  input  logic       empty_i,
  output logic       pop_o,
  tdp_out_if.source  res_o
);

  bk_state_e         state_q, state_d;
  logic [DATA_W-1:0] n_q;
  logic [DIV_W-1:0]  d_q;
  logic [SQ_W-1:0]   sq_q;
  logic              flag_q;
  logic              res_valid_q, res_flag_q;

  logic              start;
  logic              done_a, done_b;
  logic [DIV_W-1:0]  rem_a, rem_b, dvs_a, dvs_b;
  logic              hit, too_big, slot_free;

  assign dvs_a     = d_q;
  assign dvs_b     = d_q + PAIR_STEP;
  assign hit       = (rem_a == '0) || (rem_b == '0);
  assign too_big   = sq_q > SQ_W'(n_q);
  assign slot_free = !res_valid_q || res_o.ready;

  tdp_divider u_div_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .dividend_i (n_q),
    .divisor_i  (dvs_a),
    .done_o     (done_a),
    .rem_o      (rem_a)
  );

  tdp_divider u_div_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .dividend_i (n_q),
    .divisor_i  (dvs_b),
    .done_o     (done_b),
    .rem_o      (rem_b)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          state_d = head_i.resolved ? BK_DONE : BK_SQUARE;
        end
      end
      BK_START:  state_d = BK_DIVIDE;
      BK_DIVIDE: begin
        if (done_a && done_b) begin
          state_d = hit ? BK_DONE : BK_SQUARE;
        end
      end
      BK_SQUARE: state_d = BK_BOUND;
      BK_BOUND:  state_d = too_big ? BK_DONE : BK_START;
      BK_DONE: begin
        if (slot_free) begin
          state_d = BK_IDLE;
        end
      end
      default:   state_d = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o = 1'b0;
    start = 1'b0;
    unique case (state_q)
      BK_IDLE:  pop_o = !empty_i;
      BK_START: start = 1'b1;
      default: begin
        pop_o = 1'b0;
        start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        n_q    <= head_i.value;
        flag_q <= head_i.flag;
        d_q    <= FIRST_DIV;
      end
      BK_DIVIDE: begin
        if (done_a && done_b) begin
          flag_q <= 1'b0;
          d_q    <= d_q + WHEEL_STEP;
        end
      end
      BK_SQUARE: sq_q <= SQ_W'(d_q) * SQ_W'(d_q);
      BK_BOUND: begin
        flag_q <= 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      res_valid_q <= 1'b0;
      res_flag_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_DONE && slot_free) begin
        res_valid_q <= 1'b1;
        res_flag_q  <= flag_q;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.prime_flag = res_flag_q;

endmodule

### design/trial_division_primality_test_unit.sv
// Top level of the trial division primality tester.
//
//  channel | dir | signals                     | meaning
//  --------+-----+-----------------------------+-------------------------------
//  in_i    | in  | valid, ready, value[31:0]   | signed integer to test
//  res_o   | out | valid, ready, prime_flag    | 1 when the value is prime
//
// Negative, 0..3, even and multiple-of-3 values are settled in the front; their
// result goes through the queue and the back's DONE state to the result register.
// Other values go through pop, square and bound, then rounds (start, divide in the
// two 4-bit-per-cycle remainder units, square, bound) per pair d, d+2 while
// d*d <= value: ~7720 rounds for a prime near 2^31.
// Reset: asynchronous, active low; clears queue pointers, sequencer and result valid.
// Stalls: while the back works or waits on res_o, the front keeps taking items
// into the 4-deep queue until it is full; res_o holds its item until ready is seen.
`timescale 1ns / 1ps

module trial_division_primality_test_unit
  import tdp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  tdp_in_if.sink    in_i,
  tdp_out_if.source res_o
);

  logic       push, pop, full, empty;
  tdp_entry_t entry, head;

  // front: classify trivial values, queue all items with their order kept
  tdp_front u_front (
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  tdp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  // back: trial division on the 6k +/- 1 wheel, one item at a time
  tdp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

### design/tdp_checker.sv
// Port-level checker for the primality tester, bound to the top level.
`timescale 1ns / 1ps

module tdp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic res_valid_i,
  input logic res_ready_i,
  input logic res_flag_i
);

  localparam int CAPACITY = 6;

  logic [3:0] pending_q;
  logic       in_acc, res_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign res_acc = res_valid_i && res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !res_acc) begin
      pending_q <= pending_q + 4'd1;
    end else if (res_acc && !in_acc) begin
      pending_q <= pending_q - 4'd1;
    end
  end

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result item dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_flag_i))
    else $error("result payload changed while stalled");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> pending_q != 4'd0)
    else $error("result item without an accepted input item");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 4'(CAPACITY))
    else $error("more items in flight than the design can hold");

endmodule

bind trial_division_primality_test_unit tdp_checker u_tdp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_flag_i  (res_o.prime_flag)
);

### test/trial_division_primality_test_unit_test.sv
// Self-checking testbench for the trial division primality tester.
`timescale 1ns / 1ps

module trial_division_primality_test_unit_test
  import tdp_pkg::*;
();

  // Random items after the directed list, about a hundred in all.
  localparam int RANDOM_ITEMS = 80;
  // No idling on either side once this few items are left.
  localparam int CALM_ITEMS   = 20;
  // The result side holds off for a long stretch after this many results.
  localparam int HOLD_AFTER   = 8;
  localparam int HOLD_LEN     = 300;
  // A prime near 2^31 is the slowest item. Allow several times its run with no
  // item moving on either channel.
  localparam int STALL_LIMIT  = 400_000;
  // Wait a little after the last result is checked.
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic [DATA_W-1:0] value;
    bit                flag;
  } prime_verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tdp_in_if  in_if ();
  tdp_out_if res_if ();

  trial_division_primality_test_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [DATA_W-1:0] values_to_send[$];   // filled once, drained by the driver
  prime_verdict_t    pending_verdicts[$]; // one per accepted item, oldest first

  int total_items    = 0;
  int accepted_count = 0;
  int results_seen   = 0;
  int error_count    = 0;
  int send_gap       = 0;
  int take_gap       = 0;
  int hold_cycles    = 0;
  bit hold_done      = 1'b0;
  int idle_cycles    = 0;

  // Primality of a value read as a signed DATA_W-bit number: negatives are
  // never prime, then the 6k +/- 1 wheel. The bound d*d <= n is checked as
  // d <= n / d so it cannot overflow.
  function automatic bit predict_prime(logic [DATA_W-1:0] value);
    longint unsigned n;
    longint unsigned d;
    if (value[DATA_W-1])
      return 1'b0;
    n = longint'(value);
    if (n <= 3)
      return n > 1;
    if (n % 2 == 0 || n % 3 == 0)
      return 1'b0;
    d = 5;
    while (d <= n / d) begin
      if (n % d == 0 || n % (d + 2) == 0)
        return 1'b0;
      d += 6;
    end
    return 1'b1;
  endfunction

  // Random values are kept cheap for the block: big odd candidates with no
  // small factor would each run the wheel up to the square bound, so wide
  // values are negative, even, multiples of 3 or built from a small odd factor.
  function automatic logic [DATA_W-1:0] random_value();
    logic [DATA_W-1:0] r;
    int unsigned       k;
    r = $urandom & 32'h7FFF_FFFF;
    case ($urandom_range(0, 9))
      0, 1, 2: r = $urandom_range(0, 65535);
      3: r = $urandom_range(0, 1 << 20);
      4, 5: r[DATA_W-1] = 1'b1;
      6, 7: begin
        if ($urandom_range(0, 1))
          r[0] = 1'b0;
        else
          r = r - r % 3;
      end
      default: begin
        k = 2 * $urandom_range(2, 100) + 1;
        r = k * $urandom_range(1, 32'h7FFF_FFFF / k);
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Driver: offers the next pending value, holds it until ready is seen,
  // and inserts short random gaps except near the end of the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        pending_verdicts.push_back('{value: in_if.value, flag: predict_prime(in_if.value)});
        accepted_count <= accepted_count + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap != 0) begin
          send_gap    <= send_gap - 1;
          in_if.valid <= 1'b0;
        end else if (values_to_send.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (values_to_send.size() > CALM_ITEMS && $urandom_range(0, 5) == 0) begin
          // Random gap burst: valid goes low here and send_gap counts the rest.
          send_gap    <= $urandom_range(0, 2);
          in_if.valid <= 1'b0;
        end else begin
          in_if.valid <= 1'b1;
          in_if.value <= values_to_send.pop_front();
        end
      end
    end
  end

  // Long hold-off on the result side, counted here. The driver keeps
  // offering, so the block's queue fills and its input stalls.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_cycles != 0) begin
        hold_cycles <= hold_cycles - 1;
      end else if (!hold_done && results_seen == HOLD_AFTER) begin
        hold_cycles <= HOLD_LEN;
        hold_done   <= 1'b1;
      end
    end
  end

  // Monitor: checks each result against the oldest expectation, then picks
  // ready for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        results_seen <= results_seen + 1;
        if (pending_verdicts.size() == 0) begin
          report_mismatch($sformatf("result %0b with no item outstanding",
                                    res_if.prime_flag));
        end else begin
          prime_verdict_t want;
          want = pending_verdicts.pop_front();
          if (res_if.prime_flag !== want.flag)
            report_mismatch($sformatf("value %0d (0x%08h): prime_flag %0b, expected %0b",
                                      $signed(want.value), want.value,
                                      res_if.prime_flag, want.flag));
        end
      end
      if (hold_cycles != 0) begin
        res_if.ready <= 1'b0;
      end else if (take_gap != 0) begin
        take_gap     <= take_gap - 1;
        res_if.ready <= 1'b0;
      end else if (results_seen + CALM_ITEMS < total_items && $urandom_range(0, 7) == 0) begin
        take_gap     <= $urandom_range(0, 2);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long with nothing moving on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("ERROR @%0t: no item moved for %0d cycles", $time, idle_cycles);
        $display("FAIL trial_division_primality_test_unit");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid  = 1'b0;
    in_if.value  = '0;
    res_if.ready = 1'b0;

    // Directed: sign extremes, the small values, even and multiple-of-3
    // cutoffs, composites caught by d or by d+2, prime squares right at the
    // square bound, and the slow primes near 2^31 last.
    values_to_send = '{
      32'h8000_0000,        // most negative
      32'hFFFF_FFFF,        // -1
      32'hAAAA_AAAA,        // negative, alternating bits
      32'd0, 32'd1, 32'd2, 32'd3,
      32'd4,                // smallest even above the small range
      32'd5, 32'd7,
      32'd9,                // multiple of 3
      32'd25,               // 5*5: bound hit on first divisor
      32'd35,               // 5*7: caught by d and by d+2
      32'd49,               // 7*7
      32'd143,              // 11*13
      32'd169,              // 13*13
      32'h5555_5555,        // wide, factor 5
      32'h7FFF_FFFE,        // largest even
      32'd2147117569,       // 46337^2: composite found on the last divisor
      32'd2147483629,       // large prime
      32'h7FFF_FFFF         // largest positive, prime
    };
    for (int i = 0; i < RANDOM_ITEMS; i++)
      values_to_send.push_back(random_value());
    total_items = values_to_send.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_count < total_items || pending_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0)
      $display("PASS trial_division_primality_test_unit");
    else
      $display("FAIL trial_division_primality_test_unit");
    $finish;
  end

endmodule
